/* hw/rtl/voxel_volume_downsample_merge_top_assert.svh */
// Assertion macros for the volume downsample merge block.
// Included by the top level; no other dependencies.
`ifndef VOXEL_VOLUME_DOWNSAMPLE_MERGE_TOP_ASSERT_SVH
`define VOXEL_VOLUME_DOWNSAMPLE_MERGE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define VVD_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define VVD_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define VVD_ASSERT_IMP(label, a, c)
`define VVD_ASSERT_NXT(label, a, c)
`endif
`endif

/* hw/rtl/vvdm_pkg.sv */
// Shared types and constants for the volume downsample merge block.
// No dependencies.
`timescale 1ns / 1ps
package vvdm_pkg;
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] MODE_MAX = 2'd0;
    localparam logic [1:0] MODE_MIN = 2'd1;
    localparam logic [1:0] MODE_AVG = 2'd2;

    localparam logic [2:0] CFG_SX    = 3'd0;
    localparam logic [2:0] CFG_SY    = 3'd1;
    localparam logic [2:0] CFG_SZ    = 3'd2;
    localparam logic [2:0] CFG_LIMEN = 3'd3;
    localparam logic [2:0] CFG_LIMIT = 3'd4;
    localparam logic [2:0] CFG_MODE  = 3'd5;

    localparam int SUM_BITS  = 48;
    localparam int ZERO_BITS = 46;

    // controller to datapath
    typedef struct packed {
        logic clr_step;   // clear one store entry at clr address
        logic clr_start;  // reset clear address
        logic red_init;   // load reduction working sizes
        logic red_step;   // step the reduction phases
        logic map_start;  // start index mapping divisions
        logic samp_rd;    // read store at mapped index
        logic samp_wr;    // write merged entry, update stats
        logic rd_start;   // start read finalize
        logic rd_mem;     // read store at read index
        logic div_start;  // start average division
        logic load_out;   // latch result
        logic out_zero;   // result cell_value is 0
        logic out_div;    // result from division
    } vvdm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic red_done;
        logic map_done;
        logic div_done;
        logic samp_ok;    // mapped sample index within store
        logic rd_ok;      // read index in range
        logic rd_avg;     // average mode with nonzero count
    } vvdm_stat_t;
endpackage

/* hw/rtl/vvdm_ctrl.sv */
// Controller state machine for the volume downsample merge block.
// Depends on vvdm_pkg.
`timescale 1ns / 1ps
module vvdm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output vvdm_pkg::vvdm_cmd_t ctl,
    input  vvdm_pkg::vvdm_stat_t sts
);
    import vvdm_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RED    = 4'd2;
    localparam logic [3:0] S_MAP    = 4'd3;
    localparam logic [3:0] S_SRD    = 4'd4;
    localparam logic [3:0] S_SWR    = 4'd5;
    localparam logic [3:0] S_RRD    = 4'd6;
    localparam logic [3:0] S_RCHK   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_RMAP   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        ctl        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (cmd)
                        CMD_START:
                        begin
                            ctl.red_init  = 1'b1;
                            ctl.clr_start = 1'b1;
                            state_next    = S_RED;
                        end
                        CMD_SAMPLE:
                        begin
                            ctl.map_start = 1'b1;
                            state_next    = S_MAP;
                        end
                        CMD_READ:
                        begin
                            ctl.rd_start = 1'b1;
                            state_next   = S_RMAP;
                        end
                        default:
                        begin
                            ctl.load_out = 1'b1;
                            ctl.out_zero = 1'b1;
                            ov_next      = 1'b1;
                        end
                    endcase
                end
            end
            S_RED:
            begin
                ctl.red_step = 1'b1;
                if (sts.red_done)
                begin
                    state_next = S_CLEAR;
                    ctl.load_out = 1'b1;
                    ctl.out_zero = 1'b1;
                    ov_next = 1'b1;
                end
            end
            S_MAP:
            begin
                if (sts.map_done)
                begin
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                ctl.samp_rd = 1'b1;
                state_next  = S_SWR;
            end
            S_SWR:
            begin
                ctl.samp_wr  = 1'b1;
                ctl.load_out = 1'b1;
                ctl.out_zero = 1'b1;
                ov_next      = 1'b1;
                state_next   = S_IDLE;
            end
            S_RMAP:
            begin
                ctl.rd_mem = 1'b1;
                state_next = S_RRD;
            end
            S_RRD:
            begin
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                if (sts.rd_ok && sts.rd_avg)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    ctl.load_out = 1'b1;
                    ctl.out_zero = !sts.rd_ok;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.load_out = 1'b1;
                    ctl.out_div  = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

/* hw/rtl/vvdm_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by index mapping, grid
// reduction and the average read. Depends on vvdm_pkg.
`timescale 1ns / 1ps
module vvdm_divider #(
    parameter int N_BITS = 48,
    parameter int D_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [N_BITS-1:0] numer,
    input  logic [D_BITS-1:0] denom,
    output logic              done,
    output logic [N_BITS-1:0] quot
);
    import vvdm_pkg::*;

    localparam int CW = $clog2(N_BITS + 1);

    logic [N_BITS-1:0] q_reg, q_next;
    logic [D_BITS:0]   r_reg, r_next;
    logic [D_BITS-1:0] d_reg;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [D_BITS:0]   trial;

    assign quot = q_reg;
    assign done = busy_reg && (cnt_reg == CW'(0));

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[D_BITS-1:0], q_reg[N_BITS-1]};
        if (start)
        begin
            q_next    = numer;
            r_next    = '0;
            cnt_next  = CW'(N_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(0))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
                if (trial >= {1'b0, d_reg})
                begin
                    r_next = trial - {1'b0, d_reg};
                    q_next = {q_reg[N_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_next = trial;
                    q_next = {q_reg[N_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg <= denom;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end
endmodule

/* hw/rtl/vvdm_datapath.sv */
// Datapath: cell store, statistics, grid reduction and index mapping.
// Depends on vvdm_pkg and vvdm_divider.
`timescale 1ns / 1ps
module vvdm_datapath #(
    parameter int STORE_DEPTH = 65536,
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [36:0]           cfg_data,
    input  logic [31:0]           sample_value,
    input  logic [15:0]           read_index,
    input  vvdm_pkg::vvdm_cmd_t   ctl,
    output vvdm_pkg::vvdm_stat_t  sts,
    output logic [31:0]           cell_value,
    output logic [31:0]           min_nonzero,
    output logic [31:0]           max_value,
    output logic [45:0]           zeros_total,
    output logic [14:0]           reduced_x,
    output logic [14:0]           reduced_y,
    output logic [14:0]           reduced_z,
    output logic                  error_flag
);
    import vvdm_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CB = COUNT_BITS;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};
    localparam logic [SUM_BITS-1:0] SMAX = {SUM_BITS{1'b1}};
    localparam logic [ZERO_BITS-1:0] ZMAX = {ZERO_BITS{1'b1}};
    localparam logic [45:0] DEPTH46 = 46'(STORE_DEPTH);

    // configuration
    logic [14:0] csx_reg, csy_reg, csz_reg;
    logic        clen_reg;
    logic [36:0] clim_reg;
    logic [1:0]  cmode_reg;
    // latched run
    logic [14:0] sx_reg, sy_reg, sz_reg, gx_reg, gy_reg, gz_reg;
    logic [1:0]  mode_reg;
    logic [14:0] px_reg, py_reg, pz_reg;
    logic [31:0] lnz_reg, grt_reg;
    logic [45:0] zer_reg;
    logic        fault_reg;
    logic [15:0] dx_reg, dy_reg, dz_reg;
    logic [45:0] vol_reg;
    logic [1:0]  rph_reg;
    logic [29:0] xy_reg;
    // payload held from the accepted beat
    logic [31:0] sval_reg;
    logic [15:0] ridx_reg;

    // store
    logic [SUM_BITS+CB-1:0] mem [STORE_DEPTH];
    logic [SUM_BITS+CB-1:0] rdat_reg;
    logic [AW:0]            clr_reg;
    logic [AW-1:0]          widx_reg;
    logic                   wok_reg;

    // reduction round on the working sizes held in gx/gy/gz
    logic pick_x, pick_y, pick_z, over;
    assign over   = clen_reg && ({vol_reg, 2'b00} > {11'd0, clim_reg});
    assign pick_x = gx_reg >= gy_reg && gx_reg >= gz_reg && gx_reg > 15'd1;
    assign pick_y = !pick_x && gy_reg >= gx_reg && gy_reg >= gz_reg && gy_reg > 15'd1;
    assign pick_z = !pick_x && !pick_y && gz_reg > 15'd1;

    // shared divider: mapping and reduction ceil-division and average
    logic        dv_start, dv_done;
    logic [47:0] dv_num, dv_q;
    logic [31:0] dv_den;
    logic [1:0]  mph_reg;
    logic        mbusy_reg, rbusy_reg;
    logic [14:0] cx_reg;
    logic [29:0] cxy_reg;
    logic [14:0] map_c;
    logic [14:0] map_g, map_i, map_s;
    logic [15:0] rdiv;
    logic [14:0] rsz;

    vvdm_divider #(.N_BITS(48), .D_BITS(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .numer (dv_num),
        .denom (dv_den),
        .done  (dv_done),
        .quot  (dv_q)
    );

    always_comb
    begin
        case (mph_reg)
            2'd0:    begin map_i = px_reg; map_g = gx_reg; map_s = sx_reg; end
            2'd1:    begin map_i = py_reg; map_g = gy_reg; map_s = sy_reg; end
            default: begin map_i = pz_reg; map_g = gz_reg; map_s = sz_reg; end
        endcase
        rsz  = pick_x ? gx_reg : (pick_y ? gy_reg : gz_reg);
        rdiv = pick_x ? dx_reg : (pick_y ? dy_reg : dz_reg);
    end

    logic ok_run;
    assign ok_run = sx_reg != 15'd0 && sy_reg != 15'd0 && sz_reg != 15'd0 && px_reg < sx_reg;

    logic        map_first, map_go, red_go;
    assign map_go    = ctl.map_start && ok_run;
    // a reduction round starts in the test phase when over budget, idle and some size is above one
    assign red_go    = ctl.red_step && rph_reg == 2'd2 && !rbusy_reg && over &&
                       (pick_x || pick_y || pick_z);
    assign map_first = map_go;

    always_comb
    begin
        dv_start = 1'b0;
        dv_num   = '0;
        dv_den   = '0;
        if (ctl.div_start)
        begin
            dv_start = 1'b1;
            dv_num   = rdat_reg[SUM_BITS+CB-1:CB];
            dv_den   = 32'(rdat_reg[CB-1:0]);
        end
        else if (map_first)
        begin
            dv_start = 1'b1;
            dv_num   = 48'(px_reg) * 48'(gx_reg);
            dv_den   = 32'(sx_reg);
        end
        else if (mbusy_reg && dv_done && mph_reg != 2'd2)
        begin
            dv_start = 1'b1;
            if (mph_reg == 2'd0)
            begin
                dv_num = 48'(py_reg) * 48'(gy_reg);
                dv_den = 32'(sy_reg);
            end
            else
            begin
                dv_num = 48'(pz_reg) * 48'(gz_reg);
                dv_den = 32'(sz_reg);
            end
        end
        else if (red_go)
        begin
            dv_start = 1'b1;
            dv_num   = 48'(rsz) + 48'(rdiv) - 48'd1;
            dv_den   = 32'(rdiv);
        end
    end

    assign map_c = (dv_q >= 48'(map_g)) ? map_g - 15'd1 : dv_q[14:0];

    // linear index once the z coordinate is known; x*gy+y is already held
    logic [45:0] lin;
    assign lin = 46'(cxy_reg) * 46'(gz_reg) + 46'(map_c);

    logic [45:0] rd_lin;
    assign rd_lin = 46'(ridx_reg);

    assign sts.clr_done = clr_reg == (AW+1)'(STORE_DEPTH - 1);
    assign sts.red_done = rph_reg == 2'd3;
    assign sts.map_done = !ok_run && !mbusy_reg || (mbusy_reg && dv_done && mph_reg == 2'd2);
    assign sts.div_done = dv_done && !mbusy_reg && !rbusy_reg;
    assign sts.samp_ok  = wok_reg;
    assign sts.rd_ok    = rd_lin < vol_reg && rd_lin < DEPTH46;
    assign sts.rd_avg   = mode_reg == MODE_AVG && rdat_reg[CB-1:0] != '0;

    // merge
    logic [SAMPLE_BITS-1:0] sv;
    logic [31:0]            v;
    logic [SUM_BITS-1:0]    old_s, new_s;
    logic [CB-1:0]          old_c, new_c;
    logic [SUM_BITS:0]      sum;
    assign sv    = sval_reg[SAMPLE_BITS-1:0];
    assign v     = 32'(sv);
    assign old_s = rdat_reg[SUM_BITS+CB-1:CB];
    assign old_c = rdat_reg[CB-1:0];
    assign sum   = {1'b0, old_s} + (SUM_BITS+1)'(v);
    always_comb
    begin
        new_s = old_s;
        case (mode_reg)
            MODE_MIN:
                if (old_c == '0 || 48'(v) < old_s) new_s = 48'(v);
            MODE_AVG:
                if (old_c != CMAX) new_s = sum[SUM_BITS] ? SMAX : sum[SUM_BITS-1:0];
            default:
                if (48'(v) > old_s) new_s = 48'(v);
        endcase
        new_c = (old_c == CMAX) ? old_c : old_c + CB'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr_step)
        begin
            mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (ctl.samp_wr && wok_reg)
        begin
            mem[widx_reg] <= {new_s, new_c};
        end
        if (ctl.samp_rd)
        begin
            rdat_reg <= mem[widx_reg];
        end
        else if (ctl.rd_mem)
        begin
            rdat_reg <= mem[ridx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csx_reg <= 15'd1; csy_reg <= 15'd1; csz_reg <= 15'd1;
            clen_reg <= 1'b1; clim_reg <= 37'd262144; cmode_reg <= MODE_MAX;
            sx_reg <= 15'd1; sy_reg <= 15'd1; sz_reg <= 15'd1;
            gx_reg <= 15'd1; gy_reg <= 15'd1; gz_reg <= 15'd1;
            mode_reg <= MODE_MAX;
            px_reg <= '0; py_reg <= '0; pz_reg <= '0;
            lnz_reg <= '1; grt_reg <= '0; zer_reg <= '0; fault_reg <= 1'b0;
            dx_reg <= 16'd2; dy_reg <= 16'd2; dz_reg <= 16'd2;
            vol_reg <= 46'd1; rph_reg <= '0; xy_reg <= '0;
            clr_reg <= '0; widx_reg <= '0; wok_reg <= 1'b0;
            mph_reg <= '0; mbusy_reg <= 1'b0; rbusy_reg <= 1'b0;
            cx_reg <= '0; cxy_reg <= '0;
            sval_reg <= '0; ridx_reg <= '0;
            cell_value <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SX:    csx_reg   <= cfg_data[14:0];
                    CFG_SY:    csy_reg   <= cfg_data[14:0];
                    CFG_SZ:    csz_reg   <= cfg_data[14:0];
                    CFG_LIMEN: clen_reg  <= cfg_data[0];
                    CFG_LIMIT: clim_reg  <= cfg_data;
                    CFG_MODE:  cmode_reg <= cfg_data[1:0];
                    default:   ;
                endcase
            end
            // hold the payload of the accepted beat
            if (ctl.map_start)
            begin
                sval_reg <= sample_value;
            end
            if (ctl.rd_start)
            begin
                ridx_reg <= read_index;
            end
            if (ctl.clr_start)
            begin
                clr_reg <= '0;
            end
            else if (ctl.clr_step && !sts.clr_done)
            begin
                clr_reg <= clr_reg + (AW+1)'(1);
            end
            // start: latch, clear stats, then reduce
            if (ctl.red_init)
            begin
                sx_reg <= csx_reg; sy_reg <= csy_reg; sz_reg <= csz_reg;
                gx_reg <= csx_reg; gy_reg <= csy_reg; gz_reg <= csz_reg;
                mode_reg <= cmode_reg;
                px_reg <= '0; py_reg <= '0; pz_reg <= '0;
                lnz_reg <= '1; grt_reg <= '0; zer_reg <= '0; fault_reg <= 1'b0;
                dx_reg <= 16'd2; dy_reg <= 16'd2; dz_reg <= 16'd2;
                rph_reg <= 2'd0; rbusy_reg <= 1'b0;
            end
            else if (ctl.red_step)
            begin
                // phase 0: x*y, phase 1: volume, phase 2: test/round, 3: done
                case (rph_reg)
                    2'd0:
                    begin
                        xy_reg  <= 30'(gx_reg) * 30'(gy_reg);
                        rph_reg <= 2'd1;
                    end
                    2'd1:
                    begin
                        vol_reg <= 46'(xy_reg) * 46'(gz_reg);
                        rph_reg <= 2'd2;
                    end
                    2'd2:
                    begin
                        if (rbusy_reg)
                        begin
                            if (dv_done)
                            begin
                                rbusy_reg <= 1'b0;
                                rph_reg   <= 2'd0;
                                if (pick_x)
                                begin
                                    gx_reg <= dv_q[14:0]; dx_reg <= dx_reg + 16'd1;
                                end
                                else if (pick_y)
                                begin
                                    gy_reg <= dv_q[14:0]; dy_reg <= dy_reg + 16'd1;
                                end
                                else
                                begin
                                    gz_reg <= dv_q[14:0]; dz_reg <= dz_reg + 16'd1;
                                end
                            end
                        end
                        else if (red_go)
                        begin
                            rbusy_reg <= 1'b1;
                        end
                        else
                        begin
                            rph_reg <= 2'd3;
                            if (vol_reg > DEPTH46) fault_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            // sample index mapping over the shared divider
            if (map_go)
            begin
                mbusy_reg <= 1'b1;
                mph_reg   <= 2'd0;
            end
            else if (ctl.map_start)
            begin
                fault_reg <= 1'b1;
                wok_reg   <= 1'b0;
            end
            else if (mbusy_reg && dv_done)
            begin
                case (mph_reg)
                    2'd0:
                    begin
                        cx_reg <= map_c; mph_reg <= 2'd1;
                    end
                    2'd1:
                    begin
                        cxy_reg <= 30'(cx_reg) * 30'(gy_reg) + 30'(map_c);
                        mph_reg <= 2'd2;
                    end
                    default:
                    begin
                        mbusy_reg <= 1'b0;
                        widx_reg  <= lin[AW-1:0];
                        wok_reg   <= lin < DEPTH46;
                    end
                endcase
            end
            if (ctl.samp_wr && ok_run)
            begin
                if (v == 32'd0)
                begin
                    if (zer_reg != ZMAX) zer_reg <= zer_reg + 46'd1;
                end
                else if (v < lnz_reg)
                begin
                    lnz_reg <= v;
                end
                if (v > grt_reg) grt_reg <= v;
                if (pz_reg + 15'd1 >= sz_reg)
                begin
                    pz_reg <= '0;
                    if (py_reg + 15'd1 >= sy_reg)
                    begin
                        py_reg <= '0;
                        px_reg <= px_reg + 15'd1;
                    end
                    else
                    begin
                        py_reg <= py_reg + 15'd1;
                    end
                end
                else
                begin
                    pz_reg <= pz_reg + 15'd1;
                end
            end
            if (ctl.load_out)
            begin
                if (ctl.out_zero)
                    cell_value <= '0;
                else if (ctl.out_div)
                    cell_value <= dv_q[31:0];
                else if (mode_reg == MODE_MIN || mode_reg == MODE_AVG)
                    cell_value <= (rdat_reg[CB-1:0] == '0) ? 32'd0 :
                                  rdat_reg[CB+31:CB];
                else
                    cell_value <= rdat_reg[CB+31:CB];
            end
        end
    end

    assign min_nonzero = lnz_reg;
    assign max_value   = grt_reg;
    assign zeros_total = zer_reg;
    assign reduced_x   = gx_reg;
    assign reduced_y   = gy_reg;
    assign reduced_z   = gz_reg;
    assign error_flag  = fault_reg;
endmodule

/* hw/rtl/voxel_volume_downsample_merge_top.sv */
// Top level of the volume downsample merge block.
// Depends on vvdm_pkg, vvdm_ctrl, vvdm_datapath and the assertion header.
// One command at a time. A sample runs three coordinate divisions on the
// shared 48-step restoring divider, then a store read and a merge write. A
// read reads the store and, in average mode with a nonzero count, runs the
// division. A start runs reduction rounds, each with its divide, then a
// clearing pass through every entry of the cell store, as does reset; no
// command is taken during the pass.
`timescale 1ns / 1ps
`include "voxel_volume_downsample_merge_top_assert.svh"
module voxel_volume_downsample_merge_top #(
    parameter int STORE_DEPTH = 65536,
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [36:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] sample_value,
    input  logic [15:0] read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] cell_value,
    output logic [31:0] min_nonzero,
    output logic [31:0] max_value,
    output logic [45:0] zeros_total,
    output logic [14:0] reduced_x,
    output logic [14:0] reduced_y,
    output logic [14:0] reduced_z,
    output logic        error_flag
);
    import vvdm_pkg::*;

    vvdm_cmd_t  ctl;
    vvdm_stat_t sts;

    vvdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    vvdm_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_value (sample_value),
        .read_index   (read_index),
        .ctl          (ctl),
        .sts          (sts),
        .cell_value   (cell_value),
        .min_nonzero  (min_nonzero),
        .max_value    (max_value),
        .zeros_total  (zeros_total),
        .reduced_x    (reduced_x),
        .reduced_y    (reduced_y),
        .reduced_z    (reduced_z),
        .error_flag   (error_flag)
    );

    `VVD_ASSERT_NXT(a_acc_out, in_valid && in_ready && cmd == CMD_NOP, out_valid)
    `VVD_ASSERT_IMP(a_no_clr_wr, ctl.clr_step, !ctl.samp_wr)
    `VVD_ASSERT_IMP(a_no_accept_busy, ctl.samp_rd || ctl.rd_mem, !in_ready)
endmodule
